// ===== rtl/serpent_key_schedule_top_defines.svh =====
// Assertion macros for the Serpent key schedule.
// Each macro asserts on the rising edge of clk_i and is disabled while rst_ni is low.
// Synthesis builds see empty bodies.
`ifndef SERPENT_KEY_SCHEDULE_TOP_DEFINES_SVH
`define SERPENT_KEY_SCHEDULE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SKS_ASSERT(lbl, prop, msg)
`define SKS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sks_pkg.sv =====
`timescale 1ns / 1ps

package sks_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned KeyBits    = 256;
  localparam int unsigned LenW       = 9;
  localparam int unsigned RoundW     = 6;
  localparam int unsigned WindowLen  = 8;
  localparam int unsigned PrekeyRot  = 11;

  localparam logic [WordW-1:0]  GoldenFrac = 32'h9e3779b9;
  localparam logic [RoundW-1:0] LastRound  = 6'd32;

  // Serpent S-boxes S0..S7.
  localparam logic [3:0] SboxTable [8][16] = '{
    '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
      4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
    '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
      4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
      4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
    '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
      4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
    '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
    '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
      4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
    '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
      4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
    '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
      4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic [RoundW-1:0] round;
  } cmd_t;

  // One prekey word: rotl11 of the xor of four window taps, the constant and the index.
  function automatic logic [WordW-1:0] prekey(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b,
                                              input logic [WordW-1:0] c,
                                              input logic [WordW-1:0] d,
                                              input logic [7:0]       idx);
    logic [WordW-1:0] t;
    t = a ^ b ^ c ^ d ^ GoldenFrac ^ {{(WordW-8){1'b0}}, idx};
    return (t << PrekeyRot) | (t >> (WordW - PrekeyRot));
  endfunction

  function automatic logic [3:0] sbox(input logic [2:0] box, input logic [3:0] x);
    return SboxTable[box][x];
  endfunction

endpackage

// ===== rtl/sks_if.sv =====
`timescale 1ns / 1ps

// Key request channel.
interface sks_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_word_a;
  logic [63:0] key_word_b;
  logic [63:0] key_word_c;
  logic [63:0] key_word_d;
  logic [8:0]  key_length;

  modport source (output valid, key_word_a, key_word_b, key_word_c, key_word_d, key_length,
                  input ready);
  modport sink (input valid, key_word_a, key_word_b, key_word_c, key_word_d, key_length,
                output ready);
endinterface

// Round key request channel.
interface sks_subkey_if;
  logic        valid;
  logic        ready;
  logic [5:0]  round_number;
  logic [31:0] subkey_word0;
  logic [31:0] subkey_word1;
  logic [31:0] subkey_word2;
  logic [31:0] subkey_word3;
  logic        last_key;

  modport source (output valid, round_number, subkey_word0, subkey_word1, subkey_word2,
                  subkey_word3, last_key, input ready);
  modport sink (input valid, round_number, subkey_word0, subkey_word1, subkey_word2,
                subkey_word3, last_key, output ready);
endinterface

// ===== rtl/sks_datapath.sv =====
`timescale 1ns / 1ps

module sks_datapath (
  input  logic                                 clk_i,
  input  sks_pkg::cmd_t                        cmd_i,
  input  logic [63:0]                          key_word_a_i,
  input  logic [63:0]                          key_word_b_i,
  input  logic [63:0]                          key_word_c_i,
  input  logic [63:0]                          key_word_d_i,
  input  logic [sks_pkg::LenW-1:0]             key_length_i,
  output logic [sks_pkg::RoundW-1:0]           round_number_o,
  output logic [sks_pkg::WordW-1:0]            subkey_word0_o,
  output logic [sks_pkg::WordW-1:0]            subkey_word1_o,
  output logic [sks_pkg::WordW-1:0]            subkey_word2_o,
  output logic [sks_pkg::WordW-1:0]            subkey_word3_o,
  output logic                                 last_key_o
);

  logic [sks_pkg::KeyBits-1:0]                            key_raw;
  logic [sks_pkg::KeyBits-1:0]                            key_pad;
  logic [sks_pkg::WindowLen-1:0][sks_pkg::WordW-1:0]      window_q;
  logic [sks_pkg::WindowLen-1:0][sks_pkg::WordW-1:0]      window_d;
  logic [3:0][sks_pkg::WordW-1:0]                         pk;
  logic [3:0][sks_pkg::WordW-1:0]                         kw;
  logic [2:0]                                             box_sel;
  logic [3:0][sks_pkg::WordW-1:0]                         kw_q;
  logic [sks_pkg::RoundW-1:0]                             round_q;
  logic                                                   last_q;

  // Keep key bits below the length and set the pad bit at the length itself.
  assign key_raw = {key_word_d_i, key_word_c_i, key_word_b_i, key_word_a_i};

  always_comb begin
    for (int b = 0; b < sks_pkg::KeyBits; b++) begin
      key_pad[b] = (key_raw[b] & (sks_pkg::LenW'(b) < key_length_i))
                 | (sks_pkg::LenW'(b) == key_length_i);
    end
  end

  // Four chained prekey words per round key.
  always_comb begin
    pk[0] = sks_pkg::prekey(window_q[0], window_q[3], window_q[5], window_q[7],
                            {cmd_i.round, 2'd0});
    pk[1] = sks_pkg::prekey(window_q[1], window_q[4], window_q[6], pk[0],
                            {cmd_i.round, 2'd1});
    pk[2] = sks_pkg::prekey(window_q[2], window_q[5], window_q[7], pk[1],
                            {cmd_i.round, 2'd2});
    pk[3] = sks_pkg::prekey(window_q[3], window_q[6], pk[0], pk[2],
                            {cmd_i.round, 2'd3});
  end

  // Bitsliced S-box layer; round n uses box (3 - n) mod 8.
  assign box_sel = 3'd3 - cmd_i.round[2:0];

  always_comb begin
    logic [3:0] nib;
    logic [3:0] s;
    kw = '0;
    for (int j = 0; j < sks_pkg::WordW; j++) begin
      nib = {pk[3][j], pk[2][j], pk[1][j], pk[0][j]};
      s   = sks_pkg::sbox(box_sel, nib);
      for (int t = 0; t < 4; t++) begin
        kw[t][j] = s[t];
      end
    end
  end

  // Window load from the key, or slide by four prekey words.
  always_comb begin
    window_d = window_q;
    if (cmd_i.load) begin
      for (int k = 0; k < sks_pkg::WindowLen; k++) begin
        window_d[k] = key_pad[k*sks_pkg::WordW +: sks_pkg::WordW];
      end
    end else if (cmd_i.step) begin
      window_d = {pk[3], pk[2], pk[1], pk[0], window_q[7], window_q[6], window_q[5],
                  window_q[4]};
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
  end

  // Output register for the round key.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      kw_q    <= kw;
      round_q <= cmd_i.round;
      last_q  <= (cmd_i.round == sks_pkg::LastRound);
    end
  end

  assign round_number_o = round_q;
  assign subkey_word0_o = kw_q[0];
  assign subkey_word1_o = kw_q[1];
  assign subkey_word2_o = kw_q[2];
  assign subkey_word3_o = kw_q[3];
  assign last_key_o     = last_q;

endmodule

// ===== rtl/sks_ctrl.sv =====
`timescale 1ns / 1ps
`include "serpent_key_schedule_top_defines.svh"

module sks_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          key_valid_i,
  output logic          key_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sks_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                     state_q, state_d;
  logic [sks_pkg::RoundW-1:0] round_q, round_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;
  logic                       step;

  assign key_ready_o = (state_q == ST_IDLE);
  assign accept      = key_valid_i && key_ready_o;
  // A round key is produced when the output register is free or being emptied.
  assign step        = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);

  // Run sequencing over the 33 round keys.
  always_comb begin
    state_d = state_q;
    round_d = round_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          round_d = '0;
        end
      end
      ST_RUN: begin
        if (step) begin
          if (round_q == sks_pkg::LastRound) begin
            state_d = ST_IDLE;
            round_d = '0;
          end else begin
            round_d = round_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        round_d = '0;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.step  = step;
  assign cmd_o.round = round_q;

  `SKS_ASSERT_NEXT(a_accept_starts_run, accept, (state_q == ST_RUN) && (round_q == '0), "accepted key did not start a run at round zero")
  `SKS_ASSERT_NEXT(a_last_ends_run, step && (round_q == sks_pkg::LastRound), state_q == ST_IDLE, "run did not end after the last round key")
  `SKS_ASSERT(a_idle_round_zero, (state_q != ST_IDLE) || (round_q == '0), "round counter not zero while idle")
  `SKS_ASSERT(a_no_overwrite, !step || !out_valid_q || out_ready_i, "round key overwrote an untaken result")

endmodule

// ===== rtl/serpent_key_schedule_top.sv =====
`timescale 1ns / 1ps

// Serpent key schedule for user keys of up to 256 bits. A key request carries the key, least
// significant bit first, and its length in bits; shorter keys get a single one bit appended and
// are zero filled, and lengths above 256 act as 256. The block answers with the 33 round keys
// K0..K32 in order, round_number giving the index and last_key marking K32. After the cycle
// that accepts a key, one round key is produced per cycle whenever the output register is free
// or being emptied. Each round key comes from the combinational datapath: four chained prekey
// words (xor and rotate by eleven) followed by the bitsliced S-box layer. A new key is taken
// only after the previous run has produced its last round key.
module serpent_key_schedule_top (
  input  logic clk_i,
  input  logic rst_ni,
  sks_key_if.sink      key_i,
  sks_subkey_if.source subkey_o
);

  sks_pkg::cmd_t cmd;

  sks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (key_i.valid),
    .key_ready_o (key_i.ready),
    .out_valid_o (subkey_o.valid),
    .out_ready_i (subkey_o.ready),
    .cmd_o       (cmd)
  );

  sks_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .key_word_a_i   (key_i.key_word_a),
    .key_word_b_i   (key_i.key_word_b),
    .key_word_c_i   (key_i.key_word_c),
    .key_word_d_i   (key_i.key_word_d),
    .key_length_i   (key_i.key_length),
    .round_number_o (subkey_o.round_number),
    .subkey_word0_o (subkey_o.subkey_word0),
    .subkey_word1_o (subkey_o.subkey_word1),
    .subkey_word2_o (subkey_o.subkey_word2),
    .subkey_word3_o (subkey_o.subkey_word3),
    .last_key_o     (subkey_o.last_key)
  );

endmodule

// ===== sim/tb_serpent_key_schedule_top.sv =====
`timescale 1ns / 1ps

// One expected round key, with the fields of the round key channel.
typedef struct packed {
  logic [5:0]       round;
  logic [3:0][31:0] words;
  logic             last;
} round_key_t;

// Fractional part of the golden ratio, mixed into every prekey word.
localparam logic [31:0] PrekeyPhi = 32'h9e3779b9;

// Serpent S-boxes S7..S0, one 64-bit row each; nibble x of a row is the image of x.
localparam logic [7:0][63:0] SboxRows = {
  64'h6539_AC47_B28E_0FD1,
  64'h0A3D_F19E_B648_5C27,
  64'h176D_8E30_C9A4_B25F,
  64'hD7E9_A452_6B0C_38F1,
  64'hE57A_421D_369C_8BF0,
  64'h25B0_4E1D_FAC3_9768,
  64'h43D6_8EB1_A509_72CF,
  64'hC907_24DE_B56A_1F83
};

// Holds the round keys still owed by the block and compares what comes out.
class round_key_board;
  round_key_t  expected_q[$];
  int unsigned keys_seen;
  int unsigned errors;

  function new();
    keys_seen = 0;
    errors    = 0;
  endfunction

  // Expand one accepted key into its 33 round keys.
  function void note_key(input logic [63:0] wa, input logic [63:0] wb, input logic [63:0] wc,
                         input logic [63:0] wd, input logic [8:0] len);
    logic [255:0]     key;
    logic [31:0]      window [8];
    logic [31:0]      mix;
    logic [31:0]      fresh;
    logic [3:0][31:0] pre;
    logic [3:0]       nib;
    logic [3:0]       sub;
    logic [63:0]      row;
    int unsigned      bits;
    round_key_t       rk;
    // Lengths above 256 saturate; bits at and above the length read as zero.
    bits = (len > 9'd256) ? 256 : int'(len);
    key = {wd, wc, wb, wa} & ~({256{1'b1}} << bits);
    if (bits < 256) begin
      key[bits] = 1'b1;
    end
    for (int k = 0; k < 8; k++) begin
      window[k] = key[32*k +: 32];
    end
    for (int r = 0; r < 33; r++) begin
      // Four chained prekey words for this round key.
      for (int t = 0; t < 4; t++) begin
        mix = window[0] ^ window[3] ^ window[5] ^ window[7] ^ PrekeyPhi ^ 32'(4 * r + t);
        fresh = {mix[20:0], mix[31:21]};
        for (int k = 0; k < 7; k++) begin
          window[k] = window[k + 1];
        end
        window[7] = fresh;
        pre[t] = fresh;
      end
      // Bitsliced S-box, box (3 - r) mod 8.
      row = SboxRows[(3 - r) & 7];
      for (int j = 0; j < 32; j++) begin
        nib = {pre[3][j], pre[2][j], pre[1][j], pre[0][j]};
        sub = row[4 * nib +: 4];
        for (int t = 0; t < 4; t++) begin
          rk.words[t][j] = sub[t];
        end
      end
      rk.round = 6'(r);
      rk.last  = (r == 32);
      expected_q.push_back(rk);
    end
    keys_seen++;
  endfunction

  function void compare_field(input string name, input int unsigned round,
                              input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: round key %0d field %s: expected %h, actual %h",
               $time, round, name, want, got);
    end
  endfunction

  // Compare one accepted round key with the oldest one owed.
  function void check_subkey(input round_key_t got);
    round_key_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected round key: expected none, actual round %0d %h",
               $time, got.round, got.words);
      return;
    end
    want = expected_q.pop_front();
    compare_field("round_number", want.round, 32'(want.round), 32'(got.round));
    compare_field("subkey_word0", want.round, want.words[0], got.words[0]);
    compare_field("subkey_word1", want.round, want.words[1], got.words[1]);
    compare_field("subkey_word2", want.round, want.words[2], got.words[2]);
    compare_field("subkey_word3", want.round, want.words[3], got.words[3]);
    compare_field("last_key", want.round, 32'(want.last), 32'(got.last));
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_serpent_key_schedule_top;

  logic clk_i;
  logic rst_ni;

  sks_key_if    key_ch ();
  sks_subkey_if round_key_ch ();

  round_key_board board;

  serpent_key_schedule_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_ch),
    .subkey_o (round_key_ch)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // Key word that is sometimes all zeros or all ones.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Key length that favors the standard sizes and the word boundaries.
  function automatic logic [8:0] rand_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 9'(64 * $urandom_range(2, 4));
      4, 5, 6: return 9'($urandom_range(1, 256));
      7, 8: return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(1, 7) * 32 + $urandom_range(0, 2) - 1);
    endcase
  endfunction

  // Offer one key request and wait until the block takes it.
  task automatic send_key(input logic [63:0] wa, input logic [63:0] wb, input logic [63:0] wc,
                          input logic [63:0] wd, input logic [8:0] len, input bit no_gap);
    int unsigned gap;
    gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_ch.valid      <= 1'b1;
    key_ch.key_word_a <= wa;
    key_ch.key_word_b <= wb;
    key_ch.key_word_c <= wc;
    key_ch.key_word_d <= wd;
    key_ch.key_length <= len;
    do @(posedge clk_i); while (!key_ch.ready);
    board.note_key(wa, wb, wc, wd, len);
  endtask

  // Round key receiver: random stalls, steady stretches and one long hold-off.
  initial begin : round_key_sink
    int unsigned stall;
    int unsigned cycle;
    bit          held;
    stall = 0;
    cycle = 0;
    held  = 1'b0;
    round_key_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (!held && board.keys_seen >= 6) begin
        held  = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        stall--;
        round_key_ch.ready <= 1'b0;
      end else if ((cycle / 500) % 3 == 2) begin
        round_key_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = pick_gap() - 1;
        round_key_ch.ready <= 1'b0;
      end else begin
        round_key_ch.ready <= 1'b1;
      end
    end
  end

  // Check every round key that the receiver accepts.
  always @(posedge clk_i) begin
    round_key_t got;
    if (rst_ni && round_key_ch.valid && round_key_ch.ready) begin
      got.round    = round_key_ch.round_number;
      got.words[0] = round_key_ch.subkey_word0;
      got.words[1] = round_key_ch.subkey_word1;
      got.words[2] = round_key_ch.subkey_word2;
      got.words[3] = round_key_ch.subkey_word3;
      got.last     = round_key_ch.last_key;
      board.check_subkey(got);
    end
  end

  // Key requests: directed corner cases, then random keys.
  initial begin
    board = new();
    key_ch.valid      <= 1'b0;
    key_ch.key_word_a <= '0;
    key_ch.key_word_b <= '0;
    key_ch.key_word_c <= '0;
    key_ch.key_word_d <= '0;
    key_ch.key_length <= '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full length keys, no pad bit.
    send_key('0, '0, '0, '0, 9'd256, 1'b0);
    send_key('1, '1, '1, '1, 9'd256, 1'b0);
    // Empty key, pad bit at position zero, and all set bits ignored.
    send_key('1, '1, '1, '1, 9'd0, 1'b1);
    send_key('1, '1, '1, '1, 9'd1, 1'b1);
    send_key('0, '0, '0, '0, 9'd1, 1'b0);
    // Pad bit on and around word boundaries.
    send_key('1, '1, '1, '1, 9'd31, 1'b1);
    send_key('1, '1, '1, '1, 9'd32, 1'b1);
    send_key(rand_word(), rand_word(), rand_word(), rand_word(), 9'd33, 1'b1);
    send_key('1, '1, '1, '1, 9'd64, 1'b0);
    send_key('0, '0, '0, '0, 9'd128, 1'b0);
    send_key(rand_word(), rand_word(), rand_word(), rand_word(), 9'd128, 1'b1);
    send_key('1, '1, '1, '1, 9'd192, 1'b0);
    send_key('1, '1, '1, '1, 9'd255, 1'b1);
    // Lengths above 256 act as full length.
    send_key(rand_word(), rand_word(), rand_word(), rand_word(), 9'd257, 1'b1);
    send_key('1, '1, '1, '1, 9'd511, 1'b0);
    send_key(rand_word(), rand_word(), rand_word(), rand_word(), 9'd384, 1'b0);

    for (int n = 0; n < 114; n++) begin
      send_key(rand_word(), rand_word(), rand_word(), rand_word(), rand_length(),
               n >= 30 && n < 50);
    end
    key_ch.valid <= 1'b0;

    // Drain the owed round keys, then watch for stray ones.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
